### src/itad_pkg.sv
// ============================================================================
// itad_pkg: shared types and constants for the integer to ASCII converter
// Holds the beat payload types, mode codes, character constants and the
// digit count helpers used by the converter, the emitter and the top level.
// ============================================================================
package itad_pkg;

  // Default value width.
  localparam int ValueBitsDefault = 64;

  // Mode codes. Bit 1 selects hex; the undefined fourth code follows it.
  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2
  } itad_op_e;

  localparam int OpHexBit = 1;

  // Fixed characters.
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_X     = 8'h78;

  // Character for each digit value.
  localparam logic [7:0] DIGIT_TAB [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  // Input beat.
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] value;
  } itad_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } itad_out_t;

  // Text flags handed from the converter to the emitter.
  typedef struct packed {
    logic hex;
    logic neg;
  } itad_flags_t;

  // Emitter status seen by the top level.
  typedef struct packed {
    logic busy;
    logic done;
  } itad_emit_st_t;

  // Decimal digits needed for the largest unsigned value of the given width.
  // The hex digit count never exceeds this, so it sizes the digit register.
  function automatic int dec_digits(int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  // ASCII character of one digit.
  function automatic logic [7:0] digit_char(logic [3:0] d);
    return DIGIT_TAB[d];
  endfunction

endpackage

### src/itad_conv.sv
// ============================================================================
// itad_conv: bit-serial binary to BCD converter
// Takes the magnitude one bit per cycle, most significant first, into a
// shift-and-add-3 BCD register. Hex values load their nibbles directly.
// ============================================================================
module itad_conv #(
  parameter int VALUE_BITS = itad_pkg::ValueBitsDefault
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic [1:0]                                  op_i,
  input  logic [VALUE_BITS-1:0]                       value_i,
  output logic                                        done_o,
  output itad_pkg::itad_flags_t                       flags_o,
  output logic [4*itad_pkg::dec_digits(VALUE_BITS)-1:0] digits_o
);

  localparam int Digits = itad_pkg::dec_digits(VALUE_BITS);
  localparam int DigW   = 4 * Digits;
  localparam int CntW   = $clog2(VALUE_BITS + 1);

  logic                  busy_q;
  logic                  done_q;
  logic [CntW-1:0]       cnt_q;
  logic [VALUE_BITS-1:0] shift_q;
  logic [DigW-1:0]       bcd_q;
  logic [DigW-1:0]       bcd_adj;
  itad_pkg::itad_flags_t flags_q;

  logic                  is_hex;
  logic                  is_neg;
  logic [VALUE_BITS-1:0] mag;

  // Decode the mode and take the magnitude of a negative signed value.
  always_comb begin
    is_hex = op_i[itad_pkg::OpHexBit];
    is_neg = (op_i == itad_pkg::OP_SDEC) && value_i[VALUE_BITS-1];
    mag    = is_neg ? (~value_i + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : value_i;
  end

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_q[i*4 +: 4];
      end
    end
  end

  // Control: bit counter and completion pulse.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      // Hex finishes right after the load, decimal after the final shift.
      done_q <= (start_i && is_hex) ||
                (!start_i && busy_q && (cnt_q == {{(CntW-1){1'b0}}, 1'b1}));
      if (start_i) begin
        if (!is_hex) begin
          busy_q <= 1'b1;
          cnt_q  <= CntW'(VALUE_BITS);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - {{(CntW-1){1'b0}}, 1'b1};
        if (cnt_q == {{(CntW-1){1'b0}}, 1'b1}) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath: magnitude shifter and BCD register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      flags_q.hex <= is_hex;
      flags_q.neg <= is_neg;
      shift_q     <= mag;
      if (is_hex) begin
        bcd_q <= DigW'(mag);
      end else begin
        bcd_q <= '0;
      end
    end else if (busy_q) begin
      shift_q <= {shift_q[VALUE_BITS-2:0], 1'b0};
      bcd_q   <= {bcd_adj[DigW-2:0], shift_q[VALUE_BITS-1]};
    end
  end

  assign done_o   = done_q;
  assign flags_o  = flags_q;
  assign digits_o = bcd_q;

endmodule

### src/itad_emit.sv
// ============================================================================
// itad_emit: character emitter with output register
// Sends the prefix, drops leading zero digits, then shifts out one digit per
// beat from the top of the digit register, marking the final character.
// ============================================================================
module itad_emit #(
  parameter int VALUE_BITS = itad_pkg::ValueBitsDefault
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  logic                                          start_i,
  input  itad_pkg::itad_flags_t                         flags_i,
  input  logic [4*itad_pkg::dec_digits(VALUE_BITS)-1:0] digits_i,
  input  logic                                          out_stall_i,
  output logic                                          out_valid_o,
  output itad_pkg::itad_out_t                           out_data_o,
  output itad_pkg::itad_emit_st_t                       status_o
);

  localparam int Digits = itad_pkg::dec_digits(VALUE_BITS);
  localparam int DigW   = 4 * Digits;
  localparam int RemW   = $clog2(Digits + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRE0,
    S_PRE1,
    S_SKIP,
    S_DIG
  } state_e;

  state_e              state_q;
  logic [DigW-1:0]     dig_q;
  logic [RemW-1:0]     remain_q;
  logic                hex_q;
  logic                done_q;
  logic                out_valid_q;
  itad_pkg::itad_out_t out_q;

  logic                free;
  logic [3:0]          top_dig;
  logic                one_left;

  // The output slot takes a new beat when empty or when its beat leaves.
  assign free     = !out_valid_q || !out_stall_i;
  assign top_dig  = dig_q[DigW-1 -: 4];
  assign one_left = (remain_q == {{(RemW-1){1'b0}}, 1'b1});

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dig_q       <= '0;
      remain_q    <= '0;
      hex_q       <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // Pulse once the final character is loaded into the output register.
      done_q <= (state_q == S_DIG) && free && one_left;
      case (state_q)
        S_IDLE: begin
          if (free) begin
            out_valid_q <= 1'b0;
          end
          if (start_i) begin
            dig_q    <= digits_i;
            remain_q <= RemW'(Digits);
            hex_q    <= flags_i.hex;
            if (flags_i.hex || flags_i.neg) begin
              state_q <= S_PRE0;
            end else begin
              state_q <= S_SKIP;
            end
          end
        end
        S_PRE0: begin
          if (free) begin
            out_valid_q <= 1'b1;
            out_q.ch    <= hex_q ? itad_pkg::CH_ZERO : itad_pkg::CH_MINUS;
            out_q.last  <= 1'b0;
            state_q     <= hex_q ? S_PRE1 : S_SKIP;
          end
        end
        S_PRE1: begin
          if (free) begin
            out_valid_q <= 1'b1;
            out_q.ch    <= itad_pkg::CH_X;
            out_q.last  <= 1'b0;
            state_q     <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (free) begin
            out_valid_q <= 1'b0;
          end
          // Drop leading zeros, but always keep the final digit.
          if ((top_dig == 4'd0) && !one_left) begin
            dig_q    <= {dig_q[DigW-5:0], 4'h0};
            remain_q <= remain_q - {{(RemW-1){1'b0}}, 1'b1};
          end else begin
            state_q <= S_DIG;
          end
        end
        S_DIG: begin
          if (free) begin
            out_valid_q <= 1'b1;
            out_q.ch    <= itad_pkg::digit_char(top_dig);
            out_q.last  <= one_left;
            dig_q       <= {dig_q[DigW-5:0], 4'h0};
            remain_q    <= remain_q - {{(RemW-1){1'b0}}, 1'b1};
            if (one_left) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          if (free) begin
            out_valid_q <= 1'b0;
          end
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;
  assign status_o.busy   = (state_q != S_IDLE);
  assign status_o.done   = done_q;

endmodule

### src/int_to_ascii_dec_hex.sv
// ============================================================================
// int_to_ascii_dec_hex: binary integer to ASCII text converter
// Turns one value into signed decimal, unsigned decimal or "0x" hex text,
// one character per output beat, most significant character first.
// ============================================================================
// Usage:
//   The input channel takes one beat with a mode and a value; only the low
//   VALUE_BITS bits of the value are used. The output channel returns one
//   beat per character, with last set on the final one. Both channels move
//   a beat when valid is high and stall is low.
//   One value is in flight at a time: in_stall_o rises after the accepted
//   beat and falls in the cycle after the emitter has loaded the final
//   character into its output register. Decimal values pass through a
//   bit-serial converter; hex values load their nibbles directly. The
//   emitter loads the digits, sends each prefix character, and then drops
//   leading zeros and sends the digits from a register of Digits digits,
//   where Digits is the decimal digit count of the widest value (20 at 64 bits).
//   A stalled output beat is held in the output register and the emitter
//   waits; the next input beat may be taken while the last character waits.
//   Reset clears all control state; the block then accepts a beat at once.
// ============================================================================
module int_to_ascii_dec_hex #(
  parameter int VALUE_BITS = itad_pkg::ValueBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  itad_pkg::itad_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output itad_pkg::itad_out_t out_data_o
);

  localparam int Digits = itad_pkg::dec_digits(VALUE_BITS);

  logic                          busy_q;
  logic                          in_acc;
  logic                          conv_done;
  itad_pkg::itad_flags_t         conv_flags;
  logic [4*Digits-1:0]           conv_digits;
  itad_pkg::itad_emit_st_t       emit_st;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = busy_q;

  // Busy from the accepted beat until the final character is queued.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (in_acc) begin
      busy_q <= 1'b1;
    end else if (emit_st.done) begin
      busy_q <= 1'b0;
    end
  end

  itad_conv #(
    .VALUE_BITS(VALUE_BITS)
  ) u_conv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .op_i    (in_data_i.op),
    .value_i (in_data_i.value[VALUE_BITS-1:0]),
    .done_o  (conv_done),
    .flags_o (conv_flags),
    .digits_o(conv_digits)
  );

  itad_emit #(
    .VALUE_BITS(VALUE_BITS)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (conv_done),
    .flags_i    (conv_flags),
    .digits_i   (conv_digits),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .status_o   (emit_st)
  );

  // The converter only finishes for a value that is in flight.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    conv_done |-> busy_q)
    else $error("converter finished with no value in flight");

  // A new value never arrives while the emitter is busy.
  a_acc_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !emit_st.busy)
    else $error("value accepted while emitter busy");

  // The emitter finishing releases the input side on the next cycle.
  a_done_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_st.done |=> !busy_q)
    else $error("input still stalled after final character");

endmodule
